// File: sv/v210u_pkg.sv
// Shared types, constants and slot tables for the v210 to planar unpacker.
package v210u_pkg;

  localparam int MaxWidth  = 4096;
  localparam int MaxHeight = 4096;

  localparam int CfgW    = 13;   // width of a configuration register
  localparam int WordW   = 30;   // sample bits used from one v210 word
  localparam int SampleW = 10;
  localparam int PosW    = 12;   // column and row width on the output
  localparam int BlockW  = 10;   // four-word block index within a row
  localparam int QDepth  = 4;

  // Configuration register indexes.
  localparam logic RegFrameWidth  = 1'b0;
  localparam logic RegFrameHeight = 1'b1;

  typedef enum logic [1:0] {
    PLANE_Y = 2'd0,
    PLANE_U = 2'd1,
    PLANE_V = 2'd2
  } plane_t;

  // One classified word waiting for the back end.
  typedef struct packed {
    logic [WordW-1:0]  word;
    logic [1:0]        pos;
    logic [BlockW-1:0] block;
    logic [PosW-1:0]   row;
    logic [2:0]        keep;
  } entry_t;

  // Plane carried by a slot (low, middle, high) at a word position.
  function automatic plane_t slot_plane(input logic [1:0] pos, input logic [1:0] slot);
    plane_t p;
    unique case ({pos, slot})
      4'b00_00: p = PLANE_U;
      4'b00_01: p = PLANE_Y;
      4'b00_10: p = PLANE_V;
      4'b01_00: p = PLANE_Y;
      4'b01_01: p = PLANE_U;
      4'b01_10: p = PLANE_Y;
      4'b10_00: p = PLANE_V;
      4'b10_01: p = PLANE_Y;
      4'b10_10: p = PLANE_U;
      4'b11_00: p = PLANE_Y;
      4'b11_01: p = PLANE_V;
      4'b11_10: p = PLANE_Y;
      default:  p = PLANE_Y;
    endcase
    return p;
  endfunction

  // Offset of that slot's sample within its block: luma 0..5, chroma 0..2.
  function automatic logic [2:0] slot_offset(input logic [1:0] pos, input logic [1:0] slot);
    logic [2:0] o;
    unique case ({pos, slot})
      4'b01_00: o = 3'd1;
      4'b01_01: o = 3'd1;
      4'b01_10: o = 3'd2;
      4'b10_00: o = 3'd1;
      4'b10_01: o = 3'd3;
      4'b10_10: o = 3'd2;
      4'b11_00: o = 3'd4;
      4'b11_01: o = 3'd2;
      4'b11_10: o = 3'd5;
      default:  o = 3'd0;
    endcase
    return o;
  endfunction

  // Column of a slot's sample within its plane's row.
  function automatic logic [CfgW-1:0] slot_column(input logic [BlockW-1:0] block,
                                                  input plane_t plane,
                                                  input logic [2:0] off);
    logic [CfgW-1:0] b;
    b = CfgW'(block);
    if (plane == PLANE_Y) begin
      return (b << 2) + (b << 1) + CfgW'(off);
    end
    return (b << 1) + b + CfgW'(off);
  endfunction

endpackage

// File: sv/v210u_front.sv
// Front end: tracks row position, classifies each word and queues the kept slots.
module v210u_front
  import v210u_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic [CfgW-1:0] frame_width,
  input  logic [CfgW-1:0] frame_height,
  input  logic            accept,
  input  logic [31:0]     word,
  output logic            push,
  output entry_t          entry
);

  logic [PosW-1:0] word_in_row;
  logic [PosW-1:0] current_row;
  logic [CfgW-1:0] width;
  logic [CfgW-1:0] height;
  logic [CfgW-1:0] wir_inc;
  logic [CfgW-1:0] row_inc;
  logic [7:0]      groups;
  logic [CfgW:0]   span;
  logic            row_end;
  logic [2:0]      keep;

  always_comb begin
    width = {frame_width[CfgW-1:1], 1'b0};
    if (width < CfgW'(2)) width = CfgW'(2);
    if (width > CfgW'(MaxWidth)) width = CfgW'(MaxWidth);
    height = frame_height;
    if (height < CfgW'(1)) height = CfgW'(1);
    if (height > CfgW'(MaxHeight)) height = CfgW'(MaxHeight);
  end

  // The row ends once 48 * floor((pos + 1) / 32) reaches the width, which is
  // the same as pos + 1 reaching the padded row length in words.
  assign wir_inc = CfgW'(word_in_row) + CfgW'(1);
  assign row_inc = CfgW'(current_row) + CfgW'(1);
  assign groups  = wir_inc[CfgW-1:5];
  assign span    = ((CfgW+1)'(groups) << 5) + ((CfgW+1)'(groups) << 4);
  assign row_end = span >= (CfgW+1)'(width);

  always_comb begin
    plane_t          pl;
    logic [CfgW-1:0] col;
    keep = '0;
    for (int k = 0; k < 3; k++) begin
      pl  = slot_plane(word_in_row[1:0], 2'(k));
      col = slot_column(word_in_row[PosW-1:2], pl, slot_offset(word_in_row[1:0], 2'(k)));
      if (pl == PLANE_Y) begin
        keep[k] = col < width;
      end else begin
        keep[k] = {col[CfgW-2:0], 1'b0} < width;
      end
    end
  end

  assign push        = accept && (keep != 3'b000);
  assign entry.word  = word[WordW-1:0];
  assign entry.pos   = word_in_row[1:0];
  assign entry.block = word_in_row[PosW-1:2];
  assign entry.row   = current_row;
  assign entry.keep  = keep;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_in_row <= '0;
      current_row <= '0;
    end else if (accept) begin
      if (row_end) begin
        word_in_row <= '0;
        current_row <= (row_inc >= height) ? '0 : row_inc[PosW-1:0];
      end else begin
        word_in_row <= wir_inc[PosW-1:0];
      end
    end
  end

endmodule

// File: sv/v210u_fifo.sv
// Short queue of classified words between the front and back ends.
module v210u_fifo
  import v210u_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_data,
  input  logic   pop,
  output entry_t pop_data,
  output logic   full,
  output logic   not_empty
);

  localparam int PtrW = $clog2(QDepth);

  entry_t            mem [QDepth];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [PtrW:0]     count;

  assign full      = count == (PtrW+1)'(QDepth);
  assign not_empty = count != '0;
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PtrW'(1);
      if (pop) rd_ptr <= rd_ptr + PtrW'(1);
      if (push && !pop) begin
        count <= count + (PtrW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (PtrW+1)'(1);
      end
    end
  end

endmodule

// File: sv/v210u_back.sv
// Back end: walks the kept slots of one word and drives one sample per kept slot out.
module v210u_back
  import v210u_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  entry_t        q_data,
  output logic          pop,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [39:0]   m_tdata,
  output logic [1:0]    m_tuser,
  output logic          m_tlast
);

  entry_t          ent;
  logic            ent_valid;
  logic            out_free;
  logic [1:0]      slot;
  logic [2:0]      rest;
  plane_t          pl;
  logic [CfgW-1:0] col;

  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    if (ent.keep[0]) begin
      slot = 2'd0;
    end else if (ent.keep[1]) begin
      slot = 2'd1;
    end else begin
      slot = 2'd2;
    end
  end

  assign rest = ent.keep & ~(3'b001 << slot);
  assign pl   = slot_plane(ent.pos, slot);
  assign col  = slot_column(ent.block, pl, slot_offset(ent.pos, slot));
  assign pop  = q_valid && (!ent_valid || (out_free && rest == 3'b000));

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (out_free) m_tvalid <= ent_valid;
      if (pop) begin
        ent_valid <= 1'b1;
      end else if (out_free && rest == 3'b000) begin
        ent_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      ent <= q_data;
    end else if (out_free && ent_valid) begin
      ent.keep <= rest;
    end
    if (out_free && ent_valid) begin
      m_tdata <= {6'b0, ent.word[10*slot +: SampleW], ent.row, col[PosW-1:0]};
      m_tuser <= pl;
      m_tlast <= rest == 3'b000;
    end
  end

endmodule

// File: sv/v210_to_planar_unpacker.sv
// Top level of the v210 to planar sample unpacker.
//
//   channel  | dir | handshake          | contents (low bit first)
//   ---------+-----+--------------------+--------------------------------------------
//   s_       | in  | s_tvalid/s_tready  | tdata: packed_word[31:0]
//   m_       | out | m_tvalid/m_tready  | tdata: column[11:0], row_index[11:0],
//            |     |                    |        sample[9:0], zero pad; tuser: plane;
//            |     |                    |        tlast: last_of_word
//   cfg_     | in  | cfg_we             | index 0 frame_width, 1 frame_height
//
// The front end takes one word per cycle while its four-entry queue has room.
// The back end delivers one sample per cycle while the receiver is ready, so a
// word that carries three samples holds it longest and the single output port
// sets the sustained rate on active pixels; padding words cost the back nothing.
// A word passes through the queue and the back end's entry register before its
// samples leave the output register. Reset clears the row counters, the queue
// and the output, and loads 1920 by 1080. Either side may stall without the other.
module v210_to_planar_unpacker
  import v210u_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [31:0]     s_tdata,   // packed_word[31:0]
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [39:0]     m_tdata,   // column[11:0], row_index[23:12], sample[33:24]
  output logic [1:0]      m_tuser,   // plane[1:0]
  output logic            m_tlast,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [CfgW-1:0] cfg_data
);

  logic [CfgW-1:0] frame_width;
  logic [CfgW-1:0] frame_height;
  logic            accept;
  logic            push;
  entry_t          push_data;
  logic            pop;
  entry_t          pop_data;
  logic            q_full;
  logic            q_not_empty;

  // Configuration registers; write only while the block is idle (not enforced).
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= CfgW'(1920);
      frame_height <= CfgW'(1080);
    end else if (cfg_we) begin
      if (cfg_index == RegFrameWidth) frame_width <= cfg_data;
      if (cfg_index == RegFrameHeight) frame_height <= cfg_data;
    end
  end

  // A word is taken whenever the queue can hold its classified form.
  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  v210u_front u_front (
    .clk          (clk),
    .rst          (rst),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .accept       (accept),
    .word         (s_tdata),
    .push         (push),
    .entry        (push_data)
  );

  v210u_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  v210u_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_not_empty),
    .q_data   (pop_data),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

// File: dv/testbench.sv
// Self-checking testbench for the v210 to planar sample unpacker.
`timescale 1ns / 1ps

module testbench
  import v210u_pkg::*;
();

  localparam int ClkPeriod = 8;
  // Words sent over the whole run.
  localparam int ItemCount = 320;

  // One unpacked sample as it should leave the block.
  typedef struct {
    plane_t      plane;
    logic [11:0] column;
    logic [11:0] row;
    logic [9:0]  sample;
    logic        last;
  } plane_sample_t;

  // Tracks row position and configuration the way the block does, and holds
  // the samples that every accepted word is still owed.
  class v210_scoreboard;
    logic [12:0]   width_reg;
    logic [12:0]   height_reg;
    int unsigned   word_pos;
    int unsigned   row_pos;
    int            errors;
    plane_sample_t owed[$];

    function new();
      width_reg  = 13'd1920;
      height_reg = 13'd1080;
      word_pos   = 0;
      row_pos    = 0;
      errors     = 0;
    endfunction

    function void set_reg(logic idx, logic [12:0] value);
      if (idx == RegFrameWidth) width_reg = value;
      else height_reg = value;
    endfunction

    function int pending();
      return owed.size();
    endfunction

    // Unpacks one accepted word and queues the samples it yields.
    function void note_word(logic [31:0] word);
      plane_t        plane_lut [12] = '{PLANE_U, PLANE_Y, PLANE_V,
                                        PLANE_Y, PLANE_U, PLANE_Y,
                                        PLANE_V, PLANE_Y, PLANE_U,
                                        PLANE_Y, PLANE_V, PLANE_Y};
      int unsigned   off_lut [12] = '{0, 0, 0, 1, 1, 2, 1, 3, 2, 4, 2, 5};
      plane_sample_t batch [3];
      int unsigned   wid, hgt, row_words, slot, blk, col;
      int            n;
      bit            keep;
      wid = 32'(width_reg & 13'h1FFE);
      if (wid < 2) wid = 2;
      if (wid > MaxWidth) wid = MaxWidth;
      hgt = 32'(height_reg);
      if (hgt < 1) hgt = 1;
      if (hgt > MaxHeight) hgt = MaxHeight;
      row_words = ((wid + 47) / 48) * 32;
      blk = word_pos / 4;
      n = 0;
      for (int k = 0; k < 3; k++) begin
        slot = (word_pos % 4) * 3 + k;
        if (plane_lut[slot] == PLANE_Y) begin
          col  = blk * 6 + off_lut[slot];
          keep = col < wid;
        end else begin
          col  = blk * 3 + off_lut[slot];
          keep = 2 * col < wid;
        end
        if (keep) begin
          batch[n].plane  = plane_lut[slot];
          batch[n].column = col[11:0];
          batch[n].row    = row_pos[11:0];
          batch[n].sample = word[10*k +: 10];
          batch[n].last   = 1'b0;
          n++;
        end
      end
      if (n > 0) batch[n-1].last = 1'b1;
      for (int k = 0; k < n; k++) owed.push_back(batch[k]);
      word_pos++;
      if (word_pos >= row_words) begin
        word_pos = 0;
        row_pos++;
        if (row_pos >= hgt) row_pos = 0;
      end
    endfunction

    function void match(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_sample(logic [1:0] plane, logic [11:0] column, logic [11:0] row,
                               logic [9:0] sample, logic last);
      plane_sample_t e;
      if (owed.size() == 0) begin
        $error("sample with nothing owed: plane %0d column %0d row %0d value %0d",
               plane, column, row, sample);
        errors++;
        return;
      end
      e = owed.pop_front();
      match("plane", 32'(e.plane), 32'(plane));
      match("column", 32'(e.column), 32'(column));
      match("row_index", 32'(e.row), 32'(row));
      match("sample", 32'(e.sample), 32'(sample));
      match("last_of_word", 32'(e.last), 32'(last));
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;    // packed_word[31:0]
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;    // column[11:0], row_index[23:12], sample[33:24], zero pad
  logic [1:0]  m_tuser;    // plane[1:0]
  logic        m_tlast;    // last_of_word
  logic        cfg_we;
  logic        cfg_index;
  logic [12:0] cfg_data;

  v210_scoreboard sb;
  bit             idle_on;      // random gaps on both sides when set
  int             n_sent;       // words accepted so far
  int             ready_hold;

  v210_to_planar_unpacker dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #(ClkPeriod / 2) clk = ~clk;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #(8_000_000);
    $display("TB_ERROR");
    $finish;
  end

  // Both handshakes are sampled at the rising edge, where the inputs driven
  // on the falling edge are stable. A word accepted at this edge cannot have
  // produced a sample at the same edge, so noting it first is safe.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        sb.note_word(s_tdata);
        n_sent++;
      end
      if (m_tvalid && m_tready)
        sb.check_sample(m_tuser, m_tdata[11:0], m_tdata[23:12], m_tdata[33:24], m_tlast);
    end
  end

  // Receiver back-pressure: mostly ready, short stalls, now and then a long one.
  initial begin
    m_tready   = 1'b0;
    ready_hold = 0;
    forever begin
      @(negedge clk);
      if (ready_hold > 0) begin
        ready_hold--;
        m_tready <= 1'b0;
      end else if (!idle_on) begin
        m_tready <= 1'b1;
      end else begin
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) begin
          m_tready <= 1'b1;
        end else if (r < 93) begin
          ready_hold = $urandom_range(0, 2);
          m_tready <= 1'b0;
        end else begin
          ready_hold = $urandom_range(8, 40);
          m_tready <= 1'b0;
        end
      end
    end
  end

  // Idle cycles the sender leaves after a word.
  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offers one word from a falling edge until it is taken. At the following
  // falling edge, with a nonzero idle count, tvalid drops and the data bus
  // carries noise until that idle count has run out; otherwise the task
  // returns there and tvalid stays high for the next word.
  task automatic send_word(logic [31:0] word, int idle_after);
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    if (idle_after > 0) begin
      s_tvalid <= 1'b0;
      s_tdata  <= $urandom;
      repeat (idle_after) @(negedge clk);
    end
  endtask

  // Waits until every owed sample has come out, then idles before anything
  // else changes.
  task automatic drain();
    while (sb.pending() != 0) @(posedge clk);
    repeat (12) @(negedge clk);
  endtask

  // Writes both registers on consecutive cycles; the block is idle here.
  task automatic configure(logic [12:0] width, logic [12:0] height);
    cfg_we    <= 1'b1;
    cfg_index <= RegFrameWidth;
    cfg_data  <= width;
    @(negedge clk);
    cfg_index <= RegFrameHeight;
    cfg_data  <= height;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cfg_data  <= 13'($urandom);
    sb.set_reg(RegFrameWidth, width);
    sb.set_reg(RegFrameHeight, height);
  endtask

  function automatic logic [12:0] pick_width();
    case ($urandom_range(0, 9)) inside
      0:       return 13'($urandom_range(0, 5));
      1, 2:    return 13'(48 * $urandom_range(1, 4) - 2 * $urandom_range(0, 2));
      3, 4, 5: return 13'($urandom_range(2, 200));
      6:       return 13'($urandom_range(MaxWidth + 1, 8191));
      7:       return 13'h1FFF;
      default: return 13'($urandom_range(6, 100));
    endcase
  endfunction

  function automatic logic [12:0] pick_height();
    case ($urandom_range(0, 7))
      0:       return 13'd0;
      1:       return 13'h1FFF;
      2:       return 13'($urandom_range(MaxHeight + 1, 8190));
      default: return 13'($urandom_range(1, 4));
    endcase
  endfunction

  initial begin
    int n_words;
    int phase;
    logic [31:0] patterns [4];
    patterns   = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h2AAA_AAAA, 32'h1555_5555};
    sb         = new();
    idle_on    = 1'b0;
    n_sent     = 0;
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    cfg_we     = 1'b0;
    cfg_index  = RegFrameWidth;
    cfg_data   = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // The reset size of 1920 by 1080: one full four-word block, so every
    // word position is seen with all three samples kept and the field
    // extremes in every slot.
    for (int i = 0; i < 4; i++) send_word(patterns[i], i == 3 ? 1 : 0);
    drain();

    // An odd width that rounds down to the minimum and a zero height: the
    // width becomes two pixels and the frame a single row. The counters carry
    // over from the block above, so the rest of this row is padding, after
    // which the row wraps and the two-pixel tail yields only its own samples.
    configure(13'd3, 13'd0);
    for (int i = 0; i < 32; i++) send_word(patterns[i % 4] ^ $urandom_range(0, 7), 0);
    send_word(32'h3FFF_FFFF, 1);
    drain();

    // A width above the largest, clamped to it, with a two-row frame; the
    // words run on from the current position at full rate.
    configure(13'h1FFF, 13'd2);
    for (int i = 0; i < 40; i++)
      send_word($urandom, i == 39 ? 1 : 0);
    drain();

    // Random phases: each one picks a new size and keeps going from the
    // current position, so a size that shrinks below that position wraps the
    // counters on the next word. Idling is switched per phase so that some
    // phases run at full rate.
    phase = 0;
    while (n_sent < ItemCount) begin
      configure(pick_width(), pick_height());
      idle_on = ($urandom_range(0, 3) != 0);
      n_words = $urandom_range(16, 96);
      if (n_words > ItemCount - n_sent) n_words = ItemCount - n_sent;
      for (int i = 0; i < n_words; i++) begin
        if (i == n_words - 1) begin
          send_word($urandom, pick_gap() + 1);
        end else if (phase == 1 && i == n_words / 2) begin
          // The sender holds off until everything owed so far has arrived.
          send_word($urandom, 1);
          drain();
        end else begin
          send_word($urandom, pick_gap());
        end
      end
      drain();
      phase++;
    end

    idle_on = 1'b0;
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: v210_to_planar_unpacker.f
sv/v210u_pkg.sv
sv/v210u_front.sv
sv/v210u_fifo.sv
sv/v210u_back.sv
sv/v210_to_planar_unpacker.sv
dv/testbench.sv
